// ----- rtl/prc_pkg.sv -----
// Shared types and constants for the primitive root census block.
package prc_pkg;

	localparam int CNT_W = 32;
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAP1 = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAP2 = 2'd2;

	localparam logic [CFG_W-1:0] BASE_RST = 16'd10;
	localparam logic [CFG_W-1:0] GAP1_RST = 16'd20;
	localparam logic [CFG_W-1:0] GAP2_RST = 16'd60;

	// Classification of one factor word by the front end.
	typedef enum logic [1:0] {
		CLS_SKIP  = 2'd0,
		CLS_FAIL  = 2'd1,
		CLS_TEST  = 2'd2
	} cls_t;

	// Word handed from the front end to the back end.
	typedef struct packed {
		logic [31:0] prime;
		logic [31:0] factor;
		logic        last;
		cls_t        cls;
	} job_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == '1) ? c : c + 1'b1;
	endfunction

endpackage

// ----- rtl/prc_front.sv -----
// Front end: accepts factor words, classifies them and pushes them into a small queue.
module prc_front #(
	parameter int PRIME_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         prime,
	input  logic [31:0]         factor,
	input  logic                last_factor,
	output logic                job_valid,
	input  logic                job_pop,
	output prc_pkg::job_t       job
);
	localparam int DEPTH = 2;

	prc_pkg::job_t q_mem_q [DEPTH];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;
	logic [31:0]   p_m;
	logic          push;
	prc_pkg::job_t nj;

	assign p_m      = prime & ((PRIME_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PRIME_BITS) - 32'd1));
	assign in_stall = (cnt_q == 2'(DEPTH));
	assign push     = in_valid && !in_stall;

	// Base multiple of p: base < 2^16, so only p <= base can divide it; exact check done
	// in the back end by computing base mod p there. Here only p<2 is flagged.
	always_comb begin
		nj.prime  = p_m;
		nj.factor = factor;
		nj.last   = last_factor;
		if (p_m < 32'd2)
			nj.cls = prc_pkg::CLS_FAIL;
		else
			nj.cls = prc_pkg::CLS_TEST;
	end

	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (job_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= nj;
	end
endmodule

// ----- rtl/prc_back.sv -----
// Back end: serial divide, modular exponentiation, census counters and output register.
module prc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_pop,
	input  prc_pkg::job_t       job,
	input  logic [15:0]         base_value,
	input  logic [15:0]         gap_first,
	input  logic [15:0]         gap_second,
	input  logic [31:0]         prime_mask,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         tested_prime,
	output logic                is_primitive,
	output logic [31:0]         primes_seen,
	output logic [31:0]         primitive_count,
	output logic [31:0]         pairs_no_no,
	output logic [31:0]         pairs_no_yes,
	output logic [31:0]         pairs_yes_no,
	output logic [31:0]         pairs_yes_yes,
	output logic [31:0]         gap_pairs,
	output logic [31:0]         gap_pairs_both
);
	typedef enum logic [2:0] {
		S_IDLE, S_BMOD, S_DIV, S_SQR, S_MUL, S_FIN
	} st_t;

	st_t          st_q;
	logic [31:0]  p_q, num_q, den_q, quo_q, rem_q;
	logic [4:0]   bit_q;
	logic [31:0]  e_q, acc_q, g_q;
	logic         ok_q, last_q, run_ok_q;
	logic         have_prev_q, prev_ok_q;
	logic [31:0]  prev_p_q;
	logic [31:0]  cnt_q [8];

	logic [32:0]  rsh;
	logic [31:0]  gap;
	logic [2:0]   pair_idx;
	logic         fin_emit;

	// one modular multiply: 64-bit product reduced by a serial remainder
	logic [63:0]  mm_x_q;
	logic         mm_busy_q;
	logic         mm_sel_q;
	logic [6:0]   mm_i_q;
	logic [32:0]  mm_r_q;

	assign rsh = {mm_r_q[31:0], mm_x_q[63]};
	assign gap = (p_q - prev_p_q) & prime_mask;
	// pair table sits in cnt_q[2..5], indexed by previous flag * 2 + current flag
	assign pair_idx = 3'd2 + {1'b0, prev_ok_q, ok_q};
	assign fin_emit = (st_q == S_FIN) && last_q && (!out_valid || !out_stall);

	assign job_pop = (st_q == S_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			run_ok_q    <= 1'b1;
			have_prev_q <= 1'b0;
			prev_ok_q   <= 1'b0;
			prev_p_q    <= '0;
			out_valid   <= 1'b0;
			mm_busy_q   <= 1'b0;
			for (int i = 0; i < 8; i++) cnt_q[i] <= '0;
		end else begin
			if (out_valid && !out_stall && !fin_emit) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (job_valid) begin
						p_q    <= job.prime;
						last_q <= job.last;
						ok_q   <= run_ok_q;
						if (job.cls == prc_pkg::CLS_FAIL) begin
							ok_q <= 1'b0;
							st_q <= S_FIN;
						end else begin
							// base mod p via serial remainder
							num_q <= {16'd0, base_value};
							rem_q <= '0;
							bit_q <= 5'd31;
							den_q <= job.factor;
							st_q  <= S_BMOD;
						end
					end
				end
				S_BMOD: begin
					if ({rem_q[30:0], num_q[bit_q]} >= {1'b0, p_q} ||
					    rem_q[31]) begin
						rem_q <= {rem_q[30:0], num_q[bit_q]} - p_q;
					end else begin
						rem_q <= {rem_q[30:0], num_q[bit_q]};
					end
					if (bit_q == 5'd0) begin
						st_q <= S_DIV;
						num_q <= p_q - 32'd1;
						bit_q <= 5'd31;
						quo_q <= '0;
					end else bit_q <= bit_q - 5'd1;
				end
				S_DIV: begin
					if (bit_q == 5'd31 && den_q == 32'd0) begin
						if (rem_q == 32'd0) ok_q <= 1'b0;
						st_q <= S_FIN;
					end else if (bit_q == 5'd31 && rem_q == 32'd0) begin
						ok_q <= 1'b0;
						st_q <= S_FIN;
					end else begin
						if (bit_q == 5'd31) begin
							g_q   <= rem_q;
							acc_q <= 32'd1;
							rem_q <= '0;
						end
						// quotient bits built in e_q
						begin : div_step
							logic [32:0] t;
							t = {(bit_q == 5'd31) ? 32'd0 : quo_q, num_q[bit_q]};
							if (t >= {1'b0, den_q}) begin
								quo_q <= 32'(t - {1'b0, den_q});
								e_q   <= {e_q[30:0], 1'b1};
							end else begin
								quo_q <= t[31:0];
								e_q   <= {e_q[30:0], 1'b0};
							end
						end
						if (bit_q == 5'd0) begin
							st_q <= S_MUL;
							mm_busy_q <= 1'b0;
						end else bit_q <= bit_q - 5'd1;
					end
				end
				S_MUL: begin
					// right-to-left: acc*=g if e[0]; then g*=g
					if (!mm_busy_q) begin
						if (e_q == 32'd0) begin
							if (acc_q == 32'd1) ok_q <= 1'b0;
							st_q <= S_FIN;
						end else begin
							mm_sel_q  <= e_q[0];
							mm_x_q    <= e_q[0] ? 64'(acc_q) * 64'(g_q) : 64'(g_q) * 64'(g_q);
							mm_r_q    <= '0;
							mm_i_q    <= 7'd64;
							mm_busy_q <= 1'b1;
						end
					end else if (mm_i_q != 7'd0) begin
						mm_x_q <= {mm_x_q[62:0], 1'b0};
						mm_r_q <= (rsh >= {1'b0, p_q}) ? rsh - {1'b0, p_q} : rsh;
						mm_i_q <= mm_i_q - 7'd1;
					end else begin
						mm_busy_q <= 1'b0;
						if (mm_sel_q) begin
							acc_q <= mm_r_q[31:0];
							e_q   <= {e_q[31:1], 1'b0};
						end else begin
							g_q <= mm_r_q[31:0];
							e_q <= e_q >> 1;
						end
					end
				end
				S_FIN: begin
					if (!last_q) begin
						run_ok_q <= ok_q;
						st_q <= S_IDLE;
					end else if (!out_valid || !out_stall) begin
						run_ok_q <= 1'b1;
						cnt_q[0] <= prc_pkg::sat_inc(cnt_q[0]);
						if (ok_q) cnt_q[1] <= prc_pkg::sat_inc(cnt_q[1]);
						if (have_prev_q) begin
							cnt_q[pair_idx] <= prc_pkg::sat_inc(cnt_q[pair_idx]);
							if (gap == {16'd0, gap_first} || gap == {16'd0, gap_second}) begin
								cnt_q[6] <= prc_pkg::sat_inc(cnt_q[6]);
								if (prev_ok_q && ok_q) cnt_q[7] <= prc_pkg::sat_inc(cnt_q[7]);
							end
						end
						prev_p_q    <= p_q;
						prev_ok_q   <= ok_q;
						have_prev_q <= 1'b1;
						tested_prime <= p_q;
						is_primitive <= ok_q;
						out_valid   <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign primes_seen     = cnt_q[0];
	assign primitive_count = cnt_q[1];
	assign pairs_no_no     = cnt_q[2];
	assign pairs_no_yes    = cnt_q[3];
	assign pairs_yes_no    = cnt_q[4];
	assign pairs_yes_yes   = cnt_q[5];
	assign gap_pairs       = cnt_q[6];
	assign gap_pairs_both  = cnt_q[7];
endmodule

// ----- rtl/primitive_root_census.sv -----
// Top level of the primitive root census block.
// Usage:
//   Input channel in_valid/in_stall carries one factor word (prime, factor,
//   last_factor). All factor words of one prime arrive back to back in a run.
//   Output channel out_valid/out_stall carries one result word after each
//   word flagged last_factor, with the census counters after that prime.
//   Configuration channel cfg_valid/cfg_ready writes base_value (0),
//   gap_first (1), gap_second (2); write only while idle.
// Processing:
//   A two-entry queue separates the classifier from the exponent engine.
//   A tested word runs a base reduction and a quotient (up to 32+32
//   serial steps) plus up to 64 modular multiplies in the shared serial
//   reducer; the multiply loop sets the rate.
// Reset:
//   arst_n clears counters, queue and the pairing history; registers return
//   to base 10, gaps 20 and 60.
// Stall:
//   A held result blocks only the finishing step; the queue keeps filling until full.
module primitive_root_census #(
	parameter int PRIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] prime,
	input  logic [31:0] factor,
	input  logic        last_factor,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] tested_prime,
	output logic        is_primitive,
	output logic [31:0] primes_seen,
	output logic [31:0] primitive_count,
	output logic [31:0] pairs_no_no,
	output logic [31:0] pairs_no_yes,
	output logic [31:0] pairs_yes_no,
	output logic [31:0] pairs_yes_yes,
	output logic [31:0] gap_pairs,
	output logic [31:0] gap_pairs_both,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0]   base_q, gap1_q, gap2_q;
	logic          job_valid, job_pop;
	prc_pkg::job_t job;
	logic [31:0]   pmask;

	assign cfg_ready = 1'b1;
	assign pmask = (PRIME_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PRIME_BITS) - 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= prc_pkg::BASE_RST;
			gap1_q <= prc_pkg::GAP1_RST;
			gap2_q <= prc_pkg::GAP2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				prc_pkg::REG_BASE: base_q <= cfg_data;
				prc_pkg::REG_GAP1: gap1_q <= cfg_data;
				prc_pkg::REG_GAP2: gap2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	prc_front #(.PRIME_BITS(PRIME_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .prime, .factor, .last_factor,
		.job_valid, .job_pop, .job
	);

	prc_back u_back (
		.clk, .arst_n, .job_valid, .job_pop, .job,
		.base_value(base_q), .gap_first(gap1_q), .gap_second(gap2_q),
		.prime_mask(pmask), .out_valid, .out_stall, .tested_prime, .is_primitive,
		.primes_seen, .primitive_count, .pairs_no_no, .pairs_no_yes,
		.pairs_yes_no, .pairs_yes_yes, .gap_pairs, .gap_pairs_both
	);
endmodule
